### design/fr_pkg.sv
// ----------------------------------------------------------------------------
// fr_pkg
// Shared constants for the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

	// width of every index, angle and result port
	localparam int DATA_W = 16;
	// fraction bits of the index format (Q3.13)
	localparam int IDX_FRAC = 13;

endpackage

### design/fresnel_reflectance.sv
// ----------------------------------------------------------------------------
// fresnel_reflectance
// Unpolarized Fresnel reflectance and transmittance, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the output is not stalled and returns
// one result per transaction, in order. Stages 1 and 2 form the radicand,
// FRAC_BITS+1 stages of the square root give the transmitted cosine, stage 3
// multiplies, stage 4 forms sums and differences, FRAC_BITS stages of the two
// parallel dividers give the amplitude ratios, then stage 5 squares and the
// output register follows. A stall on a valid output freezes the whole
// pipeline and is passed to in_stall in the same cycle.
module fresnel_reflectance import fr_pkg::*; #(
	parameter int FRAC_BITS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] n_incident,
	input  logic [DATA_W-1:0] n_transmit,
	input  logic [DATA_W-1:0] ratio_sq,
	input  logic [DATA_W-1:0] sin_sq,
	input  logic [DATA_W-1:0] cos_incident,
	input  logic              total_reflect,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] reflectance,
	output logic [DATA_W-1:0] transmittance,
	output logic              degenerate
);

	localparam int RW   = FRAC_BITS + 1;
	localparam int CW   = (RW > DATA_W) ? RW : DATA_W;
	localparam int PW   = DATA_W + CW;
	localparam int SW   = PW + 1;
	localparam int PRW  = 2*DATA_W - IDX_FRAC;
	localparam int CMPW = (PRW > RW) ? PRW : RW;
	localparam int OW   = (RW + 1 > DATA_W) ? RW + 1 : DATA_W;
	localparam int SBW  = 3*DATA_W + 2;

	localparam logic [CMPW-1:0] ONE_C = CMPW'(1) << FRAC_BITS;
	localparam logic [RW-1:0]   ONE_R = RW'(1) << FRAC_BITS;
	localparam logic [OW-1:0]   ONE_O = OW'(1) << FRAC_BITS;

	logic en;

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: index-ratio times sine squared
	logic              v_s1, tir_s1;
	logic [2*DATA_W-1:0] prod_s1;
	logic [DATA_W-1:0] ni_s1, nt_s1, ci_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ratio_sq * sin_sq;
			ni_s1   <= n_incident;
			nt_s1   <= n_transmit;
			ci_s1   <= cos_incident;
			tir_s1  <= total_reflect;
		end
	end

	// stage 2: clamped radicand 1 - ratio_sq*sin_sq
	logic [CMPW-1:0] prod_c;
	logic            v_s2, tir_s2;
	logic [RW-1:0]   rad_s2;
	logic [DATA_W-1:0] ni_s2, nt_s2, ci_s2;

	assign prod_c = CMPW'(prod_s1[2*DATA_W-1:IDX_FRAC]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2 <= (prod_c >= ONE_C) ? '0 : RW'(ONE_C - prod_c);
			ni_s2  <= ni_s1;
			nt_s2  <= nt_s1;
			ci_s2  <= ci_s1;
			tir_s2 <= tir_s1;
		end
	end

	// square root stages
	logic [2*RW-1:0] radicand;
	logic [RW-1:0]   cos_t;
	logic [SBW-1:0]  sb_in, sb_out;

	assign radicand = (2*RW)'({rad_s2, {FRAC_BITS{1'b0}}});
	assign sb_in    = {v_s2, tir_s2, ni_s2, nt_s2, ci_s2};

	fr_isqrt #(.RW(RW)) u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (radicand),
		.root (cos_t)
	);

	fr_delay #(.WIDTH(SBW), .DEPTH(RW)) u_sb_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (sb_in),
		.dout   (sb_out)
	);

	// stage 3: the four index-cosine products
	logic              v_s3, tir_s3;
	logic [PW-1:0]     a1_s3, b1_s3, a2_s3, b2_s3;
	logic [DATA_W-1:0] ni_d, nt_d, ci_d;
	logic              v_d, tir_d;
	logic [CW-1:0]     ct_w, ci_w;

	assign {v_d, tir_d, ni_d, nt_d, ci_d} = sb_out;
	assign ct_w = CW'(cos_t);
	assign ci_w = CW'(ci_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s3  <= ni_d * ci_w;
			b1_s3  <= nt_d * ct_w;
			a2_s3  <= nt_d * ci_w;
			b2_s3  <= ni_d * ct_w;
			tir_s3 <= tir_d;
		end
	end

	// stage 4: numerators, denominators, special cases
	logic          v_s4, tir_s4, deg_s4, full1_s4, full2_s4;
	logic [SW-1:0] num1_s4, den1_s4, num2_s4, den2_s4;
	logic [SW-1:0] n1, d1, n2, d2;

	assign n1 = (a1_s3 >= b1_s3) ? SW'(a1_s3 - b1_s3) : SW'(b1_s3 - a1_s3);
	assign n2 = (a2_s3 >= b2_s3) ? SW'(a2_s3 - b2_s3) : SW'(b2_s3 - a2_s3);
	assign d1 = SW'(a1_s3) + SW'(b1_s3);
	assign d2 = SW'(a2_s3) + SW'(b2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s4  <= n1;
			den1_s4  <= d1;
			num2_s4  <= n2;
			den2_s4  <= d2;
			// numerator equals denominator when one term is zero: ratio is one
			full1_s4 <= (n1 >= d1);
			full2_s4 <= (n2 >= d2);
			deg_s4   <= (d1 == '0) || (d2 == '0);
			tir_s4   <= tir_s3;
		end
	end

	// divider stages
	logic [FRAC_BITS-1:0] q1, q2;
	logic [4:0]           fl_in, fl_out;

	assign fl_in = {v_s4, tir_s4, deg_s4, full1_s4, full2_s4};

	fr_fdiv #(.W(SW), .F(FRAC_BITS)) u_div_s (
		.clk (clk),
		.en  (en),
		.num (num1_s4),
		.den (den1_s4),
		.quo (q1)
	);

	fr_fdiv #(.W(SW), .F(FRAC_BITS)) u_div_p (
		.clk (clk),
		.en  (en),
		.num (num2_s4),
		.den (den2_s4),
		.quo (q2)
	);

	fr_delay #(.WIDTH(5), .DEPTH(FRAC_BITS)) u_fl_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (fl_in),
		.dout   (fl_out)
	);

	// stage 5: square both ratios
	logic          v_d2, tir_d2, deg_d2, full1_d2, full2_d2;
	logic [RW-1:0] r1, r2;
	logic [2*RW-1:0] sq1, sq2;
	logic          v_s5, tir_s5, deg_s5;
	logic [RW-1:0] sq1_s5, sq2_s5;

	assign {v_d2, tir_d2, deg_d2, full1_d2, full2_d2} = fl_out;
	assign r1  = full1_d2 ? ONE_R : RW'(q1);
	assign r2  = full2_d2 ? ONE_R : RW'(q2);
	assign sq1 = r1 * r1;
	assign sq2 = r2 * r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s5 <= sq1[FRAC_BITS +: RW];
			sq2_s5 <= sq2[FRAC_BITS +: RW];
			tir_s5 <= tir_d2;
			deg_s5 <= deg_d2;
		end
	end

	// output register: mean, saturation, forced cases
	logic [OW-1:0] mean, refl;
	logic [OW-1:0] trans;
	logic [DATA_W-1:0] refl_q, trans_q;
	logic          deg_q;

	assign mean  = OW'((OW'(sq1_s5) + OW'(sq2_s5)) >> 1);
	assign refl  = (tir_s5 || deg_s5 || mean > ONE_O) ? ONE_O : mean;
	assign trans = ONE_O - refl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			refl_q  <= refl[DATA_W-1:0];
			trans_q <= trans[DATA_W-1:0];
			deg_q   <= deg_s5 && !tir_s5;
		end
	end

	assign reflectance   = refl_q;
	assign transmittance = trans_q;
	assign degenerate    = deg_q;

endmodule

### design/fr_delay.sv
// ----------------------------------------------------------------------------
// fr_delay
// Enabled delay line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module fr_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				line_q[i] <= '0;
			end
		end else if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

### design/fr_isqrt.sv
// ----------------------------------------------------------------------------
// fr_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module fr_isqrt #(
	parameter int RW = 16
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	logic [RW:0]     rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] v_s    [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW:0]     rem_in;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] v_in;
		logic [RW+2:0]   rem_sh;
		logic [RW+2:0]   trial;
		logic            take;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = rad;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign v_in    = v_s[i-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_in, v_in[2*RW-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign take   = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
				root_s[i] <= {root_in[RW-2:0], take};
				v_s[i]    <= {v_in[2*RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

### design/fr_fdiv.sv
// ----------------------------------------------------------------------------
// fr_fdiv
// Pipelined restoring fraction divider: floor(num * 2^F / den), num < den.
// ----------------------------------------------------------------------------
module fr_fdiv #(
	parameter int W = 33,
	parameter int F = 15
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic [F-1:0] quo
);

	logic [W-1:0] rem_s [F];
	logic [W-1:0] den_s [F];
	logic [F-1:0] q_s   [F];

	for (genvar i = 0; i < F; i++) begin : g_stage
		logic [W-1:0] rem_in;
		logic [W-1:0] den_in;
		logic [F-1:0] q_in;
		logic [W:0]   r2;
		logic         take;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign q_in   = q_s[i-1];
		end

		assign r2   = {rem_in, 1'b0};
		assign take = (r2 >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? W'(r2 - {1'b0, den_in}) : r2[W-1:0];
				den_s[i] <= den_in;
				q_s[i]   <= {q_in[F-2:0], take};
			end
		end
	end

	assign quo = q_s[F-1];

endmodule

### design/fr_checker.sv
// ----------------------------------------------------------------------------
// fr_checker
// Port-level checks for fresnel_reflectance, bound to the top level.
// ----------------------------------------------------------------------------
module fr_checker import fr_pkg::*; #(
	parameter int FRAC_BITS = 15
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DATA_W-1:0] reflectance,
	input logic [DATA_W-1:0] transmittance,
	input logic              degenerate
);

	localparam logic [DATA_W-1:0] ONE16 = DATA_W'(64'd1 << FRAC_BITS);

	logic [DATA_W-1:0] total;

	assign total = reflectance + transmittance;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reflectance)
			&& $stable(transmittance) && $stable(degenerate))
		else $error("stalled result changed");

	// a stalled input transaction stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled input transaction withdrawn");

	// input side stalls exactly when a finished result is held
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	a_sum_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total == ONE16)
		else $error("reflectance and transmittance do not sum to one");

	a_degen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> reflectance == ONE16)
		else $error("degenerate result not saturated");

endmodule

bind fresnel_reflectance fr_checker #(.FRAC_BITS(FRAC_BITS)) u_fr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.reflectance   (reflectance),
	.transmittance (transmittance),
	.degenerate    (degenerate)
);
